// ===== hw/rtl/sdo_suc_pkg.sv =====
`default_nettype none
package sdo_suc_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_FRAME = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [1:0] KIND_TX    = 2'd0;
   localparam logic [1:0] KIND_CHUNK = 2'd1;
   localparam logic [1:0] KIND_FIN   = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
   localparam logic [1:0] STATUS_ABORT   = 2'd2;

   localparam logic [1:0] ACT_TX        = 2'd0;
   localparam logic [1:0] ACT_FIN       = 2'd1;
   localparam logic [1:0] ACT_CHUNK_FIN = 2'd2;
   localparam logic [1:0] ACT_CHUNK_TX  = 2'd3;

   localparam logic REG_NODE    = 1'b0;
   localparam logic REG_TIMEOUT = 1'b1;

   localparam logic [6:0]  NODE_RESET    = 7'd1;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   localparam logic [10:0] COB_TX_BASE = 11'h600;
   localparam logic [10:0] COB_RX_BASE = 11'h580;

   localparam logic [7:0] CCS_INIT_UPLOAD = 8'h40;
   localparam logic [7:0] CCS_SEGMENT     = 8'h60;
   localparam logic [7:0] CS_ABORT        = 8'h80;
   localparam logic [7:0] SCS_MASK        = 8'hE0;

   typedef struct packed {
      logic [1:0]  act;
      logic [10:0] tx_cob_id;
      logic [63:0] tx_bytes;
      logic [55:0] chunk_bytes;
      logic [2:0]  chunk_count;
      logic [1:0]  status;
      logic [31:0] abort_code;
   } desc_type;

   function automatic logic [63:0] mask_bytes(input logic [63:0] value,
                                              input logic [3:0] count);
      logic [63:0] result;
      result = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < count) begin
            result[8*i +: 8] = value[8*i +: 8];
         end
      end
      return result;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sdo_suc_front.sv =====
`default_nettype none
module sdo_suc_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire logic [1:0]            cmd,
   input  wire logic [15:0]           obj_index,
   input  wire logic [7:0]            obj_subindex,
   input  wire logic [10:0]           rx_cob_id,
   input  wire logic [3:0]            rx_length,
   input  wire logic [63:0]           rx_bytes,
   input  wire logic                  csr_write_enable,
   input  wire logic                  csr_index,
   input  wire logic [15:0]           csr_write_data,
   output logic                       desc_valid,
   output sdo_suc_pkg::desc_type      desc
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_INIT = 2'd1;
   localparam logic [1:0] PH_SEG  = 2'd2;

   logic [6:0]  node_ff, node_in;
   logic [15:0] timeout_ff, timeout_in;
   logic [1:0]  phase_ff, phase_in;
   logic        toggle_ff, toggle_in;
   logic [15:0] ticks_ff, ticks_in;
   logic [15:0] index_ff, index_in;
   logic [7:0]  sub_ff, sub_in;

   logic [3:0]  len_c;
   logic [63:0] d_m;
   logic [7:0]  b0;
   logic        idx_ok;
   logic        cob_ok;
   logic [10:0] tx_cob;
   logic [2:0]  init_n;
   logic [2:0]  seg_n;
   logic [63:0] init_chunk;
   logic [63:0] seg_chunk;

   always_comb begin
      len_c      = (rx_length > 4'd8) ? 4'd8 : rx_length;
      d_m        = sdo_suc_pkg::mask_bytes(rx_bytes, len_c);
      b0         = d_m[7:0];
      idx_ok     = (d_m[23:8] == index_ff) && (d_m[31:24] == sub_ff);
      cob_ok     = rx_cob_id == (sdo_suc_pkg::COB_RX_BASE + {4'b0, node_ff});
      tx_cob     = sdo_suc_pkg::COB_TX_BASE + {4'b0, node_ff};
      init_n     = b0[0] ? (3'd4 - {1'b0, b0[3:2]}) : 3'd4;
      seg_n      = 3'd7 - b0[3:1];
      init_chunk = sdo_suc_pkg::mask_bytes({32'b0, d_m[63:32]}, {1'b0, init_n});
      seg_chunk  = sdo_suc_pkg::mask_bytes({8'b0, d_m[63:8]}, {1'b0, seg_n});
   end

   always_comb begin
      node_in    = node_ff;
      timeout_in = timeout_ff;
      phase_in   = phase_ff;
      toggle_in  = toggle_ff;
      ticks_in   = ticks_ff;
      index_in   = index_ff;
      sub_in     = sub_ff;
      desc_valid = 1'b0;
      desc       = '0;
      if (csr_write_enable) begin
         unique case (csr_index)
            sdo_suc_pkg::REG_NODE:    node_in    = csr_write_data[6:0];
            sdo_suc_pkg::REG_TIMEOUT: timeout_in = csr_write_data;
            default:                  node_in    = node_ff;
         endcase
      end
      if (fire) begin
         if (cmd == sdo_suc_pkg::CMD_START) begin
            index_in         = obj_index;
            sub_in           = obj_subindex;
            toggle_in        = 1'b0;
            phase_in         = PH_INIT;
            ticks_in         = timeout_ff;
            desc_valid       = 1'b1;
            desc.act         = sdo_suc_pkg::ACT_TX;
            desc.tx_cob_id   = tx_cob;
            desc.tx_bytes    = {32'b0, obj_subindex, obj_index,
                                sdo_suc_pkg::CCS_INIT_UPLOAD};
         end else if (cmd == sdo_suc_pkg::CMD_TICK) begin
            if (phase_ff != PH_IDLE) begin
               if (ticks_ff <= 16'd1) begin
                  ticks_in    = '0;
                  phase_in    = PH_IDLE;
                  desc_valid  = 1'b1;
                  desc.act    = sdo_suc_pkg::ACT_FIN;
                  desc.status = sdo_suc_pkg::STATUS_TIMEOUT;
               end else begin
                  ticks_in = ticks_ff - 16'd1;
               end
            end
         end else if (cmd == sdo_suc_pkg::CMD_FRAME) begin
            if (phase_ff != PH_IDLE && cob_ok && len_c != 4'd0) begin
               if (phase_ff == PH_INIT) begin
                  if (len_c >= 4'd4 && idx_ok &&
                      ((b0 & sdo_suc_pkg::SCS_MASK) == sdo_suc_pkg::CCS_INIT_UPLOAD ||
                       b0 == sdo_suc_pkg::CS_ABORT)) begin
                     desc_valid = 1'b1;
                     priority if (b0 == sdo_suc_pkg::CS_ABORT) begin
                        phase_in        = PH_IDLE;
                        desc.act        = sdo_suc_pkg::ACT_FIN;
                        desc.status     = sdo_suc_pkg::STATUS_ABORT;
                        desc.abort_code = d_m[63:32];
                     end else if (b0[1]) begin
                        phase_in         = PH_IDLE;
                        desc.act         = sdo_suc_pkg::ACT_CHUNK_FIN;
                        desc.chunk_bytes = init_chunk[55:0];
                        desc.chunk_count = init_n;
                        desc.status      = sdo_suc_pkg::STATUS_OK;
                     end else begin
                        toggle_in      = 1'b0;
                        phase_in       = PH_SEG;
                        ticks_in       = timeout_ff;
                        desc.act       = sdo_suc_pkg::ACT_TX;
                        desc.tx_cob_id = tx_cob;
                        desc.tx_bytes  = {56'b0, sdo_suc_pkg::CCS_SEGMENT};
                     end
                  end
               end else if (phase_ff == PH_SEG) begin
                  if (b0 == sdo_suc_pkg::CS_ABORT) begin
                     if (len_c >= 4'd8 && idx_ok) begin
                        phase_in        = PH_IDLE;
                        desc_valid      = 1'b1;
                        desc.act        = sdo_suc_pkg::ACT_FIN;
                        desc.status     = sdo_suc_pkg::STATUS_ABORT;
                        desc.abort_code = d_m[63:32];
                     end
                  end else if (b0[7:5] == 3'b000 && b0[4] == toggle_ff) begin
                     desc_valid       = 1'b1;
                     desc.chunk_bytes = seg_chunk[55:0];
                     desc.chunk_count = seg_n;
                     desc.status      = sdo_suc_pkg::STATUS_OK;
                     if (b0[0]) begin
                        phase_in = PH_IDLE;
                        desc.act = sdo_suc_pkg::ACT_CHUNK_FIN;
                     end else begin
                        toggle_in      = ~toggle_ff;
                        ticks_in       = timeout_ff;
                        desc.act       = sdo_suc_pkg::ACT_CHUNK_TX;
                        desc.tx_cob_id = tx_cob;
                        desc.tx_bytes  = {56'b0, sdo_suc_pkg::CCS_SEGMENT |
                                                 {3'b0, ~toggle_ff, 4'b0}};
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff    <= sdo_suc_pkg::NODE_RESET;
         timeout_ff <= sdo_suc_pkg::TIMEOUT_RESET;
         phase_ff   <= PH_IDLE;
         toggle_ff  <= 1'b0;
         ticks_ff   <= '0;
         index_ff   <= '0;
         sub_ff     <= '0;
      end else begin
         node_ff    <= node_in;
         timeout_ff <= timeout_in;
         phase_ff   <= phase_in;
         toggle_ff  <= toggle_in;
         ticks_ff   <= ticks_in;
         index_ff   <= index_in;
         sub_ff     <= sub_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sdo_suc_queue.sv =====
`default_nettype none
module sdo_suc_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire sdo_suc_pkg::desc_type wr_desc,
   output logic                       q_full,
   input  wire logic                  rd_en,
   output logic                       q_empty,
   output sdo_suc_pkg::desc_type      rd_desc
);

   sdo_suc_pkg::desc_type                  slot_ff [sdo_suc_pkg::QUEUE_DEPTH];
   logic [sdo_suc_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [sdo_suc_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [sdo_suc_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;

   always_comb begin
      q_full    = count_ff == sdo_suc_pkg::QUEUE_CNT_W'(sdo_suc_pkg::QUEUE_DEPTH);
      q_empty   = count_ff == '0;
      rd_desc   = slot_ff[rd_ptr_ff];
      wr_ptr_in = wr_en ? wr_ptr_ff + sdo_suc_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + sdo_suc_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + sdo_suc_pkg::QUEUE_CNT_W'(wr_en)
                           - sdo_suc_pkg::QUEUE_CNT_W'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_desc;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sdo_suc_back.sv =====
`default_nettype none
module sdo_suc_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_empty,
   input  wire sdo_suc_pkg::desc_type q_desc,
   output logic                       q_pop,
   input  wire logic                  pop,
   output logic                       empty,
   output logic [1:0]                 rsp_kind,
   output logic [10:0]                rsp_tx_cob_id,
   output logic [63:0]                rsp_tx_bytes,
   output logic [55:0]                rsp_chunk_bytes,
   output logic [2:0]                 rsp_chunk_count,
   output logic [1:0]                 rsp_status,
   output logic [31:0]                rsp_abort_code,
   output logic                       rsp_last
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [10:0] tx_cob_id;
      logic [63:0] tx_bytes;
      logic [55:0] chunk_bytes;
      logic [2:0]  chunk_count;
      logic [1:0]  status;
      logic [31:0] abort_code;
      logic        last;
   } res_type;

   function automatic res_type first_of(input sdo_suc_pkg::desc_type d);
      res_type r;
      r = '0;
      unique case (d.act)
         sdo_suc_pkg::ACT_TX: begin
            r.kind      = sdo_suc_pkg::KIND_TX;
            r.tx_cob_id = d.tx_cob_id;
            r.tx_bytes  = d.tx_bytes;
            r.last      = 1'b1;
         end
         sdo_suc_pkg::ACT_FIN: begin
            r.kind       = sdo_suc_pkg::KIND_FIN;
            r.status     = d.status;
            r.abort_code = d.abort_code;
            r.last       = 1'b1;
         end
         sdo_suc_pkg::ACT_CHUNK_FIN, sdo_suc_pkg::ACT_CHUNK_TX: begin
            r.kind        = sdo_suc_pkg::KIND_CHUNK;
            r.chunk_bytes = d.chunk_bytes;
            r.chunk_count = d.chunk_count;
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic res_type second_of(input sdo_suc_pkg::desc_type d);
      res_type r;
      r      = '0;
      r.last = 1'b1;
      if (d.act == sdo_suc_pkg::ACT_CHUNK_TX) begin
         r.kind      = sdo_suc_pkg::KIND_TX;
         r.tx_cob_id = d.tx_cob_id;
         r.tx_bytes  = d.tx_bytes;
      end else begin
         r.kind   = sdo_suc_pkg::KIND_FIN;
         r.status = d.status;
      end
      return r;
   endfunction

   logic                  out_valid_ff, out_valid_in;
   logic                  sec_ff, sec_in;
   res_type               out_ff, out_in;
   sdo_suc_pkg::desc_type held_ff, held_in;
   logic                  load;

   always_comb begin
      empty        = ~out_valid_ff;
      load         = ~out_valid_ff | pop;
      out_valid_in = out_valid_ff;
      sec_in       = sec_ff;
      out_in       = out_ff;
      held_in      = held_ff;
      q_pop        = 1'b0;
      if (load) begin
         priority if (sec_ff) begin
            out_in       = second_of(held_ff);
            out_valid_in = 1'b1;
            sec_in       = 1'b0;
         end else if (!q_empty) begin
            q_pop        = 1'b1;
            out_in       = first_of(q_desc);
            out_valid_in = 1'b1;
            held_in      = q_desc;
            sec_in       = (q_desc.act == sdo_suc_pkg::ACT_CHUNK_FIN) ||
                           (q_desc.act == sdo_suc_pkg::ACT_CHUNK_TX);
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sec_ff       <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sec_ff       <= sec_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      held_ff <= held_in;
   end

   assign rsp_kind        = out_ff.kind;
   assign rsp_tx_cob_id   = out_ff.tx_cob_id;
   assign rsp_tx_bytes    = out_ff.tx_bytes;
   assign rsp_chunk_bytes = out_ff.chunk_bytes;
   assign rsp_chunk_count = out_ff.chunk_count;
   assign rsp_status      = out_ff.status;
   assign rsp_abort_code  = out_ff.abort_code;
   assign rsp_last        = out_ff.last;

endmodule
`default_nettype wire

// ===== hw/rtl/sdo_segmented_upload_client_unit.sv =====
// SDO upload client: reads one object dictionary entry from a CANopen server.
// Input queue: push an item (start, received frame or tick) while full is low.
// Result queue: while empty is low the oldest result is on the rsp_ ports;
// pop takes it. Each result is a frame to send, a payload chunk or the end
// of the read with its status; rsp_last marks the final result of an item.
// Configuration: csr_write_enable with csr_index 0 (node id) or 1 (timeout
// in ticks); the user must write them while idle; the block does not check.
// An item goes into the queue, then its result into the rsp_ output register.
// Throughput: one item per cycle into the front end while full is low. The
// result stage sends one result per cycle while the receiver pops, and holds
// two-result items for both. A four-entry front-to-back queue absorbs bursts.
// When the receiver stalls, the queue fills and full rises; items that cause
// no result are also held off while full is high.
// Reset clears the read state, empties both queues and restores node id 1
// and a timeout of 1000 ticks.
`default_nettype none
module sdo_segmented_upload_client_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire logic [1:0]   req_cmd,
   input  wire logic [15:0]  req_obj_index,
   input  wire logic [7:0]   req_obj_subindex,
   input  wire logic [10:0]  req_rx_cob_id,
   input  wire logic [3:0]   req_rx_length,
   input  wire logic [63:0]  req_rx_bytes,
   output logic              empty,
   input  wire logic         pop,
   output logic [1:0]        rsp_kind,
   output logic [10:0]       rsp_tx_cob_id,
   output logic [63:0]       rsp_tx_bytes,
   output logic [55:0]       rsp_chunk_bytes,
   output logic [2:0]        rsp_chunk_count,
   output logic [1:0]        rsp_status,
   output logic [31:0]       rsp_abort_code,
   output logic              rsp_last,
   input  wire logic         csr_write_enable,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_write_data
);

   logic                  fire;
   logic                  desc_valid;
   sdo_suc_pkg::desc_type desc;
   logic                  q_full;
   logic                  q_empty;
   logic                  q_pop;
   sdo_suc_pkg::desc_type q_desc;

   assign full = q_full;
   assign fire = push & ~q_full;

   sdo_suc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .fire             (fire),
      .cmd              (req_cmd),
      .obj_index        (req_obj_index),
      .obj_subindex     (req_obj_subindex),
      .rx_cob_id        (req_rx_cob_id),
      .rx_length        (req_rx_length),
      .rx_bytes         (req_rx_bytes),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .desc_valid       (desc_valid),
      .desc             (desc)
   );

   sdo_suc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (desc_valid),
      .wr_desc (desc),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .q_empty (q_empty),
      .rd_desc (q_desc)
   );

   sdo_suc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_desc          (q_desc),
      .q_pop           (q_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_kind        (rsp_kind),
      .rsp_tx_cob_id   (rsp_tx_cob_id),
      .rsp_tx_bytes    (rsp_tx_bytes),
      .rsp_chunk_bytes (rsp_chunk_bytes),
      .rsp_chunk_count (rsp_chunk_count),
      .rsp_status      (rsp_status),
      .rsp_abort_code  (rsp_abort_code),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS = 322;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef enum logic [1:0] {READ_IDLE, READ_WAIT_INIT, READ_WAIT_SEG} read_phase_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] obj_index;
      logic [7:0]  obj_subindex;
      logic [10:0] rx_cob_id;
      logic [3:0]  rx_length;
      logic [63:0] rx_bytes;
   } upload_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [10:0] tx_cob_id;
      logic [63:0] tx_bytes;
      logic [55:0] chunk_bytes;
      logic [2:0]  chunk_count;
      logic [1:0]  status;
      logic [31:0] abort_code;
      logic        last;
   } upload_res_type;

   typedef struct {
      bit             cfg_row;
      logic [6:0]     node;
      logic [15:0]    timeout;
      upload_req_type it;
      bit             typed;
      upload_res_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_cmd = '0;
   logic [15:0] req_obj_index = '0;
   logic [7:0]  req_obj_subindex = '0;
   logic [10:0] req_rx_cob_id = '0;
   logic [3:0]  req_rx_length = '0;
   logic [63:0] req_rx_bytes = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_kind;
   logic [10:0] rsp_tx_cob_id;
   logic [63:0] rsp_tx_bytes;
   logic [55:0] rsp_chunk_bytes;
   logic [2:0]  rsp_chunk_count;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_abort_code;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = sdo_suc_pkg::REG_NODE;
   logic [15:0] csr_write_data = '0;

   logic [6:0]     cfg_node = sdo_suc_pkg::NODE_RESET;
   logic [15:0]    cfg_timeout = sdo_suc_pkg::TIMEOUT_RESET;
   read_phase_type read_phase = READ_IDLE;
   logic           toggle = 1'b0;
   logic [15:0]    ticks_left = '0;
   logic [15:0]    saved_index = '0;
   logic [7:0]     saved_subindex = '0;

   upload_res_type sdo_results_due[$];
   int             fail_count = 0;
   int             cycle_count = 0;
   bit             hold_request = 1'b0;

   sdo_segmented_upload_client_unit DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_cmd(req_cmd),
      .req_obj_index(req_obj_index),
      .req_obj_subindex(req_obj_subindex),
      .req_rx_cob_id(req_rx_cob_id),
      .req_rx_length(req_rx_length),
      .req_rx_bytes(req_rx_bytes),
      .empty(empty),
      .pop(pop),
      .rsp_kind(rsp_kind),
      .rsp_tx_cob_id(rsp_tx_cob_id),
      .rsp_tx_bytes(rsp_tx_bytes),
      .rsp_chunk_bytes(rsp_chunk_bytes),
      .rsp_chunk_count(rsp_chunk_count),
      .rsp_status(rsp_status),
      .rsp_abort_code(rsp_abort_code),
      .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [10:0] tx_id();
      return sdo_suc_pkg::COB_TX_BASE + {4'd0, cfg_node};
   endfunction

   function automatic logic [10:0] rx_id();
      return sdo_suc_pkg::COB_RX_BASE + {4'd0, cfg_node};
   endfunction

   function automatic upload_res_type tx_result(input logic [10:0] cob,
                                                input logic [63:0] data);
      upload_res_type r;
      r = '0;
      r.kind = sdo_suc_pkg::KIND_TX;
      r.tx_cob_id = cob;
      r.tx_bytes = data;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic upload_res_type end_result(input logic [1:0] st,
                                                 input logic [31:0] code);
      upload_res_type r;
      r = '0;
      r.kind = sdo_suc_pkg::KIND_FIN;
      r.status = st;
      r.abort_code = code;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic upload_res_type chunk_result(input logic [55:0] bytes_in, input int n);
      upload_res_type r;
      r = '0;
      r.kind = sdo_suc_pkg::KIND_CHUNK;
      r.chunk_bytes = (n >= 7) ? bytes_in : bytes_in & ((56'd1 << (8 * n)) - 56'd1);
      r.chunk_count = 3'(n);
      return r;
   endfunction

   function automatic bit same_object(input logic [63:0] d);
      return d[23:8] == saved_index && d[31:24] == saved_subindex;
   endfunction

   function automatic int predict_upload(input upload_req_type it,
                                         output upload_res_type res[2]);
      logic [63:0] d;
      logic [7:0]  b0;
      logic [3:0]  len;
      int          n;
      res[0] = '0;
      res[1] = '0;
      case (it.cmd)
         sdo_suc_pkg::CMD_START: begin
            saved_index = it.obj_index;
            saved_subindex = it.obj_subindex;
            toggle = 1'b0;
            read_phase = READ_WAIT_INIT;
            ticks_left = cfg_timeout;
            res[0] = tx_result(tx_id(), {32'd0, saved_subindex, saved_index,
                                         sdo_suc_pkg::CCS_INIT_UPLOAD});
            return 1;
         end
         sdo_suc_pkg::CMD_TICK: begin
            if (read_phase == READ_IDLE) return 0;
            if (ticks_left <= 16'd1) begin
               ticks_left = '0;
               read_phase = READ_IDLE;
               res[0] = end_result(sdo_suc_pkg::STATUS_TIMEOUT, '0);
               return 1;
            end
            ticks_left--;
            return 0;
         end
         sdo_suc_pkg::CMD_FRAME: begin
            if (read_phase == READ_IDLE || it.rx_cob_id != rx_id() || it.rx_length == 4'd0)
               return 0;
            len = (it.rx_length > 4'd8) ? 4'd8 : it.rx_length;
            d = (len < 4'd8) ? it.rx_bytes & ((64'd1 << (8 * len)) - 64'd1) : it.rx_bytes;
            b0 = d[7:0];
            if (read_phase == READ_WAIT_INIT) begin
               if (len < 4'd4
                   || !((b0 & sdo_suc_pkg::SCS_MASK) == sdo_suc_pkg::CCS_INIT_UPLOAD
                        || b0 == sdo_suc_pkg::CS_ABORT)
                   || !same_object(d))
                  return 0;
               if (b0 == sdo_suc_pkg::CS_ABORT) begin
                  read_phase = READ_IDLE;
                  res[0] = end_result(sdo_suc_pkg::STATUS_ABORT, d[63:32]);
                  return 1;
               end
               if (b0[1]) begin
                  n = b0[0] ? 4 - int'(b0[3:2]) : 4;
                  read_phase = READ_IDLE;
                  res[0] = chunk_result({24'd0, d[63:32]}, n);
                  res[1] = end_result(sdo_suc_pkg::STATUS_OK, '0);
                  return 2;
               end
               toggle = 1'b0;
               read_phase = READ_WAIT_SEG;
               ticks_left = cfg_timeout;
               res[0] = tx_result(tx_id(), {56'd0, sdo_suc_pkg::CCS_SEGMENT});
               return 1;
            end
            if (b0 == sdo_suc_pkg::CS_ABORT) begin
               if (len < 4'd8 || !same_object(d)) return 0;
               read_phase = READ_IDLE;
               res[0] = end_result(sdo_suc_pkg::STATUS_ABORT, d[63:32]);
               return 1;
            end
            if ((b0 & sdo_suc_pkg::SCS_MASK) != 8'd0 || b0[4] != toggle) return 0;
            n = 7 - int'(b0[3:1]);
            res[0] = chunk_result(d[63:8], n);
            if (b0[0]) begin
               read_phase = READ_IDLE;
               res[1] = end_result(sdo_suc_pkg::STATUS_OK, '0);
               return 2;
            end
            toggle = ~toggle;
            ticks_left = cfg_timeout;
            res[1] = tx_result(tx_id(), {56'd0, sdo_suc_pkg::CCS_SEGMENT |
                                                {3'd0, toggle, 4'd0}});
            return 2;
         end
         default: return 0;
      endcase
   endfunction

   function automatic upload_req_type next_item();
      upload_req_type it;
      int             pick;
      int             sort;
      logic [7:0]     b0;
      it.cmd = sdo_suc_pkg::CMD_FRAME;
      it.obj_index = 16'($urandom);
      it.obj_subindex = 8'($urandom);
      it.rx_cob_id = 11'($urandom);
      it.rx_length = 4'($urandom);
      it.rx_bytes = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         it.cmd = sdo_suc_pkg::CMD_TICK;
         return it;
      end
      if (pick < 15) begin
         it.cmd = 2'($urandom);
         return it;
      end
      it.rx_cob_id = rx_id();
      if (pick < 19) return it;
      if (pick < 22) begin
         if ($urandom_range(0, 1)) it.rx_length = '0;
         else it.rx_cob_id = rx_id() ^ (11'd1 << $urandom_range(0, 10));
         return it;
      end
      if (read_phase == READ_IDLE || pick < 26) begin
         it.cmd = sdo_suc_pkg::CMD_START;
         case ($urandom_range(0, 5))
            0: begin
               it.obj_index = '0;
               it.obj_subindex = '0;
            end
            1: begin
               it.obj_index = '1;
               it.obj_subindex = '1;
            end
            default: ;
         endcase
         return it;
      end
      it.rx_bytes[31:8] = {saved_subindex, saved_index};
      if (read_phase == READ_WAIT_INIT) begin
         sort = $urandom_range(0, 9);
         it.rx_length = 4'($urandom_range(4, 15));
         if (sort == 0) b0 = sdo_suc_pkg::CS_ABORT;
         else b0 = sdo_suc_pkg::CCS_INIT_UPLOAD | (8'($urandom) & 8'h1D)
                   | ((sort < 6) ? 8'h02 : 8'h00);
         if (sort == 9) it.rx_bytes[23:16] ^= 8'($urandom_range(1, 255));
      end else begin
         sort = $urandom_range(0, 19);
         it.rx_length = 4'($urandom_range(1, 15));
         if (sort == 0) begin
            b0 = sdo_suc_pkg::CS_ABORT;
            it.rx_length = 4'($urandom_range(7, 15));
         end else begin
            b0 = {3'b000, toggle ^ (sort == 1), 3'($urandom), 1'($urandom_range(0, 3) == 0)};
         end
      end
      it.rx_bytes[7:0] = b0;
      return it;
   endfunction

   function automatic stim_row_type item_row(input logic [1:0] cmd, input logic [15:0] idx,
                                             input logic [7:0] sub, input logic [10:0] cob,
                                             input logic [3:0] len, input logic [63:0] data);
      stim_row_type r;
      r.cfg_row = 1'b0;
      r.node = '0;
      r.timeout = '0;
      r.it = {cmd, idx, sub, cob, len, data};
      r.typed = 1'b0;
      r.want = '0;
      return r;
   endfunction

   function automatic stim_row_type frame_row(input logic [10:0] cob, input logic [3:0] len,
                                              input logic [63:0] data);
      return item_row(sdo_suc_pkg::CMD_FRAME, '0, '0, cob, len, data);
   endfunction

   function automatic stim_row_type start_row(input logic [15:0] idx, input logic [7:0] sub);
      return item_row(sdo_suc_pkg::CMD_START, idx, sub, '0, '0, '0);
   endfunction

   function automatic stim_row_type tick_row();
      return item_row(sdo_suc_pkg::CMD_TICK, '0, '0, '0, '0, '0);
   endfunction

   function automatic stim_row_type with_result(input stim_row_type r,
                                                input upload_res_type want);
      stim_row_type t;
      t = r;
      t.typed = 1'b1;
      t.want = want;
      return t;
   endfunction

   function automatic stim_row_type cfg_row(input logic [6:0] node,
                                            input logic [15:0] timeout);
      stim_row_type r;
      r = tick_row();
      r.cfg_row = 1'b1;
      r.node = node;
      r.timeout = timeout;
      return r;
   endfunction

   task automatic offer(input upload_req_type it, input bit typed,
                        input upload_res_type want);
      upload_res_type res[2];
      int             n;
      push <= 1'b1;
      req_cmd <= it.cmd;
      req_obj_index <= it.obj_index;
      req_obj_subindex <= it.obj_subindex;
      req_rx_cob_id <= it.rx_cob_id;
      req_rx_length <= it.rx_length;
      req_rx_bytes <= it.rx_bytes;
      @(posedge clock);
      while (full) @(posedge clock);
      n = predict_upload(it, res);
      for (int k = 0; k < n; k++) sdo_results_due.push_back(typed ? want : res[k]);
   endtask

   task automatic settle();
      push <= 1'b0;
      while (sdo_results_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_config(input logic [6:0] node, input logic [15:0] timeout);
      settle();
      csr_write_enable <= 1'b1;
      csr_index <= sdo_suc_pkg::REG_NODE;
      csr_write_data <= {9'd0, node};
      @(posedge clock);
      csr_index <= sdo_suc_pkg::REG_TIMEOUT;
      csr_write_data <= timeout;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_node = node;
      cfg_timeout = timeout;
   endtask

   task automatic send_random(input int count, input bit gaps);
      int burst;
      int g;
      burst = $urandom_range(1, 24);
      repeat (count) begin
         offer(next_item(), 1'b0, '0);
         burst--;
         if (burst == 0) begin
            g = gaps ? $urandom_range(0, 6) : 0;
            if (g > 0) begin
               push <= 1'b0;
               repeat (g) @(posedge clock);
            end
            burst = $urandom_range(1, 24);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      upload_res_type want;
      if (!reset && pop && !empty) begin
         if (sdo_results_due.size() == 0) begin
            $error("result with nothing due: kind %0d", rsp_kind);
            fail_count++;
         end else begin
            want = sdo_results_due.pop_front();
            check_field("kind", 64'(want.kind), 64'(rsp_kind));
            check_field("tx_cob_id", 64'(want.tx_cob_id), 64'(rsp_tx_cob_id));
            check_field("tx_bytes", want.tx_bytes, rsp_tx_bytes);
            check_field("chunk_bytes", 64'(want.chunk_bytes), 64'(rsp_chunk_bytes));
            check_field("chunk_count", 64'(want.chunk_count), 64'(rsp_chunk_count));
            check_field("status", 64'(want.status), 64'(rsp_status));
            check_field("abort_code", 64'(want.abort_code), 64'(rsp_abort_code));
            check_field("last", 64'(want.last), 64'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : result_side
      logic [15:0] pattern;
      int          span;
      int          hold_left;
      bit          hold_taken;
      pattern = '1;
      span = 0;
      hold_left = 0;
      hold_taken = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else begin
            if (span == 0) begin
               case ($urandom_range(0, 3))
                  0: pattern = '1;
                  1: pattern = 16'($urandom) | 16'h0001;
                  2: pattern = 16'($urandom & $urandom & $urandom) | 16'h0001;
                  default: pattern = 16'($urandom) | 16'h8001;
               endcase
               span = $urandom_range(40, 300);
            end
            pop <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
            span--;
         end
      end
   end

   initial begin : stimulus
      stim_row_type directed[$];
      logic [6:0]   phase_node[RANDOM_PHASES];
      logic [15:0]  phase_timeout[RANDOM_PHASES];
      int           g;
      directed.push_back(with_result(start_row(16'h1018, 8'h01),
                                     tx_result(11'h601, 64'h0000_0000_0110_1840)));
      directed.push_back(tick_row());
      directed.push_back(frame_row(11'h582, 4'd8, 64'h1234_5678_0110_1843));
      directed.push_back(frame_row(11'h581, 4'd0, 64'h1234_5678_0110_1843));
      directed.push_back(frame_row(11'h581, 4'd8, 64'hDEAD_BEEF_0110_1843));
      directed.push_back(tick_row());
      directed.push_back(item_row(CMD_UNUSED, '1, '1, '1, '1, '1));
      directed.push_back(cfg_row(7'd127, 16'd1));
      directed.push_back(with_result(start_row(16'hFFFF, 8'hFF),
                                     tx_result(11'h67F, 64'h0000_0000_FFFF_FF40)));
      directed.push_back(with_result(tick_row(),
                                     end_result(sdo_suc_pkg::STATUS_TIMEOUT, '0)));
      directed.push_back(with_result(start_row(16'h0000, 8'h00),
                                     tx_result(11'h67F, 64'h0000_0000_0000_0040)));
      directed.push_back(with_result(frame_row(11'h5FF, 4'd8, 64'hFFFF_FFFF_0000_0080),
                                     end_result(sdo_suc_pkg::STATUS_ABORT, 32'hFFFF_FFFF)));
      directed.push_back(cfg_row(7'd5, 16'hFFFF));
      directed.push_back(start_row(16'h2000, 8'h03));
      directed.push_back(frame_row(11'h585, 4'd4, 64'hAAAA_AAAA_0320_0041));
      directed.push_back(frame_row(11'h585, 4'd8, 64'h1111_1111_1111_1110));
      directed.push_back(frame_row(11'h585, 4'd8, 64'h7766_5544_3322_1100));
      directed.push_back(frame_row(11'h585, 4'd1, 64'hFFFF_FFFF_FFFF_FF1E));
      directed.push_back(frame_row(11'h585, 4'd7, 64'h0000_0000_0320_0080));
      directed.push_back(frame_row(11'h585, 4'd3, 64'hFFFF_FFFF_FFFF_0007));
      directed.push_back(start_row(16'h1234, 8'h56));
      directed.push_back(start_row(16'h4321, 8'h65));
      directed.push_back(frame_row(11'h585, 4'd8, 64'h0000_0000_5612_344F));
      directed.push_back(frame_row(11'h585, 4'd15, 64'h9988_7766_6543_214F));
      directed.push_back(start_row(16'h5555, 8'hAA));
      directed.push_back(frame_row(11'h585, 4'd4, 64'h0000_0000_AA55_5540));
      directed.push_back(frame_row(11'h585, 4'd8, 64'h0800_0000_AA55_5580));

      phase_node[0] = 7'd1;
      phase_timeout[0] = 16'd1;
      phase_node[1] = 7'd127;
      phase_timeout[1] = 16'hFFFF;
      phase_node[2] = 7'($urandom_range(1, 127));
      phase_timeout[2] = 16'($urandom_range(2, 6));
      phase_node[3] = 7'd64;
      phase_timeout[3] = 16'd1000;
      phase_node[4] = 7'($urandom_range(1, 127));
      phase_timeout[4] = 16'($urandom_range(1, 65535));
      phase_node[5] = 7'($urandom_range(1, 127));
      phase_timeout[5] = 16'd3;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].cfg_row) begin
            write_config(directed[i].node, directed[i].timeout);
         end else begin
            offer(directed[i].it, directed[i].typed, directed[i].want);
            g = $urandom_range(0, 2);
            if (g > 0) begin
               push <= 1'b0;
               repeat (g) @(posedge clock);
            end
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_config(phase_node[p], phase_timeout[p]);
         if (p == 1) begin
            hold_request = 1'b1;
            send_random(60, 1'b0);
            send_random(PHASE_ITEMS - 60, 1'b1);
         end else begin
            send_random(PHASE_ITEMS, p != 3);
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
